@@ rtl/core/dssd_pkg.sv @@
// ---------------------------------------------------------------------------
// dssd_pkg
// Shared types, constants and lookup functions for the decimal
// seven-segment scanner.
// ---------------------------------------------------------------------------
package dssd_pkg;

    localparam int VALUE_W         = 16;
    localparam int DIGIT_W         = 4;
    localparam int DIGIT_COUNT     = 5;
    localparam int BCD_W           = DIGIT_W * DIGIT_COUNT;
    localparam int STEPS_PER_STAGE = 4;
    localparam int STAGE_COUNT     = VALUE_W / STEPS_PER_STAGE;
    localparam int SEL_W           = 8;
    localparam int SEG_W           = 7;
    localparam int IDX_W           = $clog2(DIGIT_COUNT);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIGIT_COUNT - 1);

    typedef logic [IDX_W-1:0]   t_digit_idx;
    typedef logic [DIGIT_W-1:0] t_digit;

    // Double-dabble working word: BCD accumulator and the bits not yet shifted in
    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } t_dab;

    // Common-cathode segment pattern, bit0 = a .. bit6 = g
    function automatic logic [SEG_W-1:0] seg_of(input t_digit d);
        logic [SEG_W-1:0] s;
        begin
            unique case (d)
                4'd0:    s = 7'h3f;
                4'd1:    s = 7'h06;
                4'd2:    s = 7'h5b;
                4'd3:    s = 7'h4f;
                4'd4:    s = 7'h66;
                4'd5:    s = 7'h6d;
                4'd6:    s = 7'h7d;
                4'd7:    s = 7'h07;
                4'd8:    s = 7'h7f;
                4'd9:    s = 7'h6f;
                default: s = 7'h00;
            endcase
            return s;
        end
    endfunction

    // Active-low position select, display positions four to eight
    function automatic logic [SEL_W-1:0] pos_of(input t_digit_idx k);
        logic [SEL_W-1:0] p;
        begin
            unique case (k)
                3'd0:    p = 8'hf7;
                3'd1:    p = 8'hef;
                3'd2:    p = 8'hdf;
                3'd3:    p = 8'hbf;
                3'd4:    p = 8'h7f;
                default: p = 8'hff;
            endcase
            return p;
        end
    endfunction

endpackage

@@ rtl/core/dssd_in_if.sv @@
// ---------------------------------------------------------------------------
// dssd_in_if
// Input channel: one 16-bit value per transaction.
// ---------------------------------------------------------------------------
interface dssd_in_if;
    import dssd_pkg::*;

    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

@@ rtl/core/dssd_out_if.sv @@
// ---------------------------------------------------------------------------
// dssd_out_if
// Output channel: one display digit per transaction.
// ---------------------------------------------------------------------------
interface dssd_out_if;
    import dssd_pkg::*;

    logic             valid;
    logic             ready;
    logic [SEL_W-1:0] digit_select;
    logic [SEG_W-1:0] segments;
    logic             last_digit;

    modport source (output valid, output digit_select, output segments,
                    output last_digit, input ready);
    modport sink   (input valid, input digit_select, input segments,
                    input last_digit, output ready);
endinterface

@@ rtl/core/decimal_seven_segment_scanner.sv @@
// Path: the first digit transaction of a value is offered once the value has passed
// the four converter stages and then the digit hold register.
// Flow: the single output channel carries five digit transactions per value and so
// sets the value rate; the converter pipeline takes a value every cycle unless stalled.
// Reset: synchronous active low, clears all valid bits; ready is high once reset
// has emptied the stages.
// ---------------------------------------------------------------------------
// decimal_seven_segment_scanner
// Converts a 16-bit value to five decimal digits and emits them as
// digit-select / seven-segment transactions for an eight-digit display.
// ---------------------------------------------------------------------------
module decimal_seven_segment_scanner (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dssd_in_if.sink    i_in,
    dssd_out_if.source o_out
);
    import dssd_pkg::*;

    logic s_valid [STAGE_COUNT+1];
    logic s_ready [STAGE_COUNT+1];
    t_dab s_data  [STAGE_COUNT+1];

    // Pipeline entry: empty BCD accumulator, value to shift in
    assign s_valid[0]  = i_in.valid;
    assign s_data[0]   = '{bcd: '0, bin: i_in.value};
    assign i_in.ready  = s_ready[0];

    // Binary-to-BCD converter stages
    for (genvar g = 0; g < STAGE_COUNT; g++) begin : g_stage
        dssd_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[g]),
            .o_ready (s_ready[g]),
            .i_data  (s_data[g]),
            .o_valid (s_valid[g+1]),
            .i_ready (s_ready[g+1]),
            .o_data  (s_data[g+1])
        );
    end

    // Digit serializer and display encoder
    dssd_serializer u_ser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_valid[STAGE_COUNT]),
        .o_ready (s_ready[STAGE_COUNT]),
        .i_data  (s_data[STAGE_COUNT]),
        .o_out   (o_out)
    );

    // A value's digits follow one another until the ones digit
    a_digits_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_digit |=> o_out.valid)
        else $error("digit sequence broken before ones digit");

    // Exactly one display position selected
    a_one_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> $onehot(~o_out.digit_select))
        else $error("digit select not one-cold");

    // Ones flag on the eighth position only
    a_last_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_digit == (o_out.digit_select == 8'h7f)))
        else $error("last flag and position disagree");

    // Ten-thousands digit stays within 0 to 6
    a_top_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.digit_select == 8'hf7) |->
            (o_out.segments == 7'h3f) || (o_out.segments == 7'h06) ||
            (o_out.segments == 7'h5b) || (o_out.segments == 7'h4f) ||
            (o_out.segments == 7'h66) || (o_out.segments == 7'h6d) ||
            (o_out.segments == 7'h7d))
        else $error("ten-thousands digit out of range");

endmodule

@@ rtl/core/dssd_dabble_stage.sv @@
// ---------------------------------------------------------------------------
// dssd_dabble_stage
// One pipeline stage of the binary-to-BCD converter: a few shift/add-3
// steps followed by a stage register with valid/ready flow control.
// ---------------------------------------------------------------------------
module dssd_dabble_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dssd_pkg::t_dab i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output dssd_pkg::t_dab o_data
);
    import dssd_pkg::*;

    logic r_valid;
    t_dab r_data;
    t_dab n_data;

    // Shift/add-3 steps of this stage
    always_comb begin
        n_data = i_data;
        for (int k = 0; k < STEPS_PER_STAGE; k++) begin
            for (int d = 0; d < DIGIT_COUNT; d++) begin
                if (n_data.bcd[d*DIGIT_W +: DIGIT_W] >= 4'd5) begin
                    n_data.bcd[d*DIGIT_W +: DIGIT_W] =
                        n_data.bcd[d*DIGIT_W +: DIGIT_W] + 4'd3;
                end
            end
            n_data.bcd = {n_data.bcd[BCD_W-2:0], n_data.bin[VALUE_W-1]};
            n_data.bin = {n_data.bin[VALUE_W-2:0], 1'b0};
        end
    end

    // Stage register advances when empty or when downstream takes it
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/core/dssd_serializer.sv @@
// ---------------------------------------------------------------------------
// dssd_serializer
// Holds the five BCD digits of one value and emits them as display
// transactions, most significant first, with the ones digit flagged.
// ---------------------------------------------------------------------------
module dssd_serializer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  dssd_pkg::t_dab i_data,
    dssd_out_if.source     o_out
);
    import dssd_pkg::*;

    logic       r_valid;
    t_digit_idx r_idx;
    t_digit     r_digits [DIGIT_COUNT];
    logic       out_fire;
    logic       at_last;

    assign at_last  = (r_idx == LAST_IDX);
    assign out_fire = r_valid && o_out.ready;
    assign o_ready  = !r_valid || (o_out.ready && at_last);

    // Control: load a new value after the last digit leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            r_idx   <= '0;
        end else if (out_fire) begin
            r_idx <= r_idx + t_digit_idx'(1);
        end
    end

    // Digit hold register, ten-thousands digit in slot zero
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            for (int k = 0; k < DIGIT_COUNT; k++) begin
                r_digits[k] <= i_data.bcd[(DIGIT_COUNT-1-k)*DIGIT_W +: DIGIT_W];
            end
        end
    end

    // Display encoding of the current digit
    assign o_out.valid        = r_valid;
    assign o_out.digit_select = pos_of(r_idx);
    assign o_out.segments     = seg_of(r_digits[r_idx]);
    assign o_out.last_digit   = at_last;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives 16-bit values into the decimal seven-segment scanner and checks
// every digit transaction (position select, segment pattern, last flag)
// against typed patterns or an in-bench decimal split. A directed table
// leads; random values under several idle/stall mixes and a long hold-off.
// ---------------------------------------------------------------------------
module testbench;
    import dssd_pkg::*;

    localparam int SEGS_W          = DIGIT_COUNT * SEG_W;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int BURST_ITEMS     = 20;
    localparam int ITEMS_PER_MIX   = 71;
    localparam int DRAIN_LIMIT     = 20000;
    localparam int TAIL_CYCLES     = 12;
    localparam int MAX_REPORTS     = 10;

    // Common-cathode patterns for digits 0..9, bit0 = a
    localparam logic [SEG_W-1:0] SEG_PATTERN [10] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
    };
    // Active-low position selects, most significant digit first
    localparam logic [SEL_W-1:0] POS_SELECT [DIGIT_COUNT] = '{
        8'hf7, 8'hef, 8'hdf, 8'hbf, 8'h7f
    };

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [SEL_W-1:0]   sel;
        logic [SEG_W-1:0]   seg;
        logic               last;
    } t_digit_entry;

    // One directed transaction; segs typed in only where known by inspection
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               typed;
        logic [SEGS_W-1:0]  segs;
    } t_directed_row;

    localparam int DIRECTED_COUNT = 25;
    localparam t_directed_row DIRECTED [DIRECTED_COUNT] = '{
        '{16'd0,     1'b1, {5{7'h3f}}},
        '{16'd65535, 1'b1, {7'h7d, 7'h6d, 7'h6d, 7'h4f, 7'h6d}},
        '{16'd60000, 1'b1, {7'h7d, {4{7'h3f}}}},
        '{16'd12345, 1'b1, {7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d}},
        '{16'd9999,  1'b1, {7'h3f, {4{7'h6f}}}},
        '{16'd8,     1'b1, {{4{7'h3f}}, 7'h7f}},
        '{16'd1,     1'b0, '0},
        '{16'd9,     1'b0, '0},
        '{16'd10,    1'b0, '0},
        '{16'd99,    1'b0, '0},
        '{16'd100,   1'b0, '0},
        '{16'd999,   1'b0, '0},
        '{16'd1000,  1'b0, '0},
        '{16'd10000, 1'b0, '0},
        '{16'd54321, 1'b0, '0},
        '{16'd59999, 1'b0, '0},
        '{16'd65530, 1'b0, '0},
        '{16'h8000,  1'b0, '0},
        '{16'h5555,  1'b0, '0},
        '{16'haaaa,  1'b0, '0},
        '{16'h00ff,  1'b0, '0},
        '{16'hff00,  1'b0, '0},
        '{16'd7890,  1'b0, '0},
        '{16'd45678, 1'b0, '0},
        '{16'd30000, 1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dssd_in_if  in_ch ();
    dssd_out_if out_ch ();

    decimal_seven_segment_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_digit_entry expected_digits[$];
    int           mismatch_count = 0;
    int           src_idle_pct   = 0;
    int           snk_stall_pct  = 0;
    int           stall_requests = 0;

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Decimal split of a value into packed segment patterns, ten-thousands on top
    function automatic logic [SEGS_W-1:0] predict_segments(input logic [VALUE_W-1:0] v);
        int unsigned       n;
        int unsigned       place;
        logic [SEGS_W-1:0] segs;
        n     = v;
        place = 10000;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            segs[(DIGIT_COUNT-1-k)*SEG_W +: SEG_W] = SEG_PATTERN[(n / place) % 10];
            place = place / 10;
        end
        return segs;
    endfunction

    // Queue the five digit transactions one accepted value produces
    function automatic void queue_digits(input logic [VALUE_W-1:0] v,
                                         input logic [SEGS_W-1:0]  segs);
        t_digit_entry e;
        for (int k = 0; k < DIGIT_COUNT; k++) begin
            e.value = v;
            e.sel   = POS_SELECT[k];
            e.seg   = segs[(DIGIT_COUNT-1-k)*SEG_W +: SEG_W];
            e.last  = (k == DIGIT_COUNT - 1);
            expected_digits.push_back(e);
        end
    endfunction

    // Random values, weighted toward digit boundaries and the top of range
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned mode;
        int unsigned p;
        int unsigned k;
        mode = $urandom_range(0, 9);
        k    = $urandom_range(0, 15);
        case (mode)
            4: return VALUE_W'($urandom_range(0, 99));
            5: begin
                p = 10 ** $urandom_range(1, 4);
                return VALUE_W'(p - 2 + $urandom_range(0, 4));
            end
            6: return VALUE_W'($urandom_range(60000, 65535));
            7: return VALUE_W'($urandom_range(0, 5) * 10000 + $urandom_range(0, 9999));
            8: return $urandom_range(0, 1) ? (16'hffff >> k) : (16'h0001 << k);
            9: return VALUE_W'($urandom_range(0, 5) * 11111);
            default: return VALUE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic void log_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // Offer one value, with optional idle cycles first; expectations queued on accept
    task automatic offer_value(input logic [VALUE_W-1:0] v, input logic [SEGS_W-1:0] segs);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        in_ch.valid <= 1'b1;
        in_ch.value <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        queue_digits(v, segs);
    endtask

    // Hold the input quiet until every queued digit has come out
    task automatic drain_display();
        int waited;
        waited = 0;
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (expected_digits.size() != 0 && waited < DRAIN_LIMIT);
    endtask

    // Stimulus
    initial begin
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.value = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, no idling
        for (int i = 0; i < DIRECTED_COUNT; i++) begin
            offer_value(DIRECTED[i].value,
                        DIRECTED[i].typed ? DIRECTED[i].segs
                                          : predict_segments(DIRECTED[i].value));
        end
        drain_display();

        // long output hold-off while values keep coming, so the input backs up
        stall_requests <= stall_requests + 1;
        for (int i = 0; i < BURST_ITEMS; i++) begin
            logic [VALUE_W-1:0] v;
            v = pick_value();
            offer_value(v, predict_segments(v));
        end

        // random values under each idle/stall mix
        for (int mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin src_idle_pct = 0;  snk_stall_pct <= 0;  end
                1: begin src_idle_pct = 86; snk_stall_pct <= 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct <= 86; end
                default: begin src_idle_pct = 14; snk_stall_pct <= 14; end
            endcase
            for (int i = 0; i < ITEMS_PER_MIX; i++) begin
                logic [VALUE_W-1:0] v;
                v = pick_value();
                offer_value(v, predict_segments(v));
            end
        end

        drain_display();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_digits.size() != 0)
            log_failure($sformatf("%0d digit transactions never arrived",
                                  expected_digits.size()));

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Output ready: random stalls, plus a long hold-off on request
    initial begin
        int stall_left;
        int stall_served;
        stall_left   = 0;
        stall_served = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else if (stall_served != stall_requests) begin
                stall_served = stall_requests;
                stall_left   = HOLD_OFF_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    // Compare each digit transaction with the oldest expectation
    always @(posedge i_clk) begin : check_digits
        t_digit_entry want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_digits.size() == 0) begin
                log_failure($sformatf("unexpected digit: sel=%h seg=%h last=%b",
                                      out_ch.digit_select, out_ch.segments,
                                      out_ch.last_digit));
            end else begin
                want = expected_digits.pop_front();
                if (out_ch.digit_select !== want.sel || out_ch.segments !== want.seg ||
                    out_ch.last_digit !== want.last) begin
                    log_failure($sformatf(
                        "value %0d: exp sel=%h seg=%h last=%b, got sel=%h seg=%h last=%b",
                        want.value, want.sel, want.seg, want.last,
                        out_ch.digit_select, out_ch.segments, out_ch.last_digit));
                end
            end
        end
    end

endmodule
